/* rtl/ffha_pkg.sv */
// ffha_pkg: shared types, constants and codes for the first-fit hole allocator.
// Used by ffha_cell and first_fit_hole_allocator; depends on nothing.
`default_nettype none
package ffha_pkg;

    localparam int AW              = 36;
    localparam int LW              = AW + 1;   // hole length while a merge runs
    localparam int MAX_HOLES_DEF   = 16;
    localparam logic [AW-1:0] ADDR_MASK = {AW{1'b1}};

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOSPACE = 2'd1;
    localparam logic [1:0] ST_ZERO    = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    typedef enum logic [2:0] {
        OP_HOLD,
        OP_ALLOC,
        OP_INSERT,
        OP_MERGE,
        OP_DROP,
        OP_MASK
    } cell_op_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_MERGE,
        S_DROP,
        S_FIN
    } seq_state_t;

    typedef struct packed {
        logic          valid;
        logic [AW-1:0] start;
        logic [LW-1:0] len;
    } hole_t;

    typedef struct packed {
        logic          hit;    // selection made at or left of this cell
        logic          rm;     // a hole was removed at or left of this cell
        logic [AW-1:0] grant;  // start of the selected hole
    } chain_t;

    typedef struct packed {
        cell_op_t      op;
        logic [AW-1:0] off;
        logic [AW-1:0] req;
    } cell_cmd_t;

    typedef struct packed {
        logic          action;
        logic [AW-1:0] range_offset;
        logic [AW-1:0] range_bytes;
    } req_t;

    typedef struct packed {
        logic [1:0]    status;
        logic [AW-1:0] granted_offset;
        logic [AW-1:0] bytes_in_use;
    } rsp_t;

endpackage
`default_nettype wire

/* rtl/ffha_cell.sv */
// ffha_cell: one hole slot of the sorted hole chain.
// Depends on ffha_pkg; instantiated in a row by first_fit_hole_allocator.
`default_nettype none
module ffha_cell (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire ffha_pkg::cell_cmd_t cmd_i,
    input  wire ffha_pkg::hole_t   left_i,
    input  wire ffha_pkg::hole_t   right_i,
    input  wire ffha_pkg::chain_t  chain_i,
    output ffha_pkg::chain_t       chain_o,
    output ffha_pkg::hole_t        hole_o
);
    import ffha_pkg::*;

    hole_t         hole_reg, hole_next;
    logic [LW:0]   my_end, left_end, right_end;
    logic          sel, first, exact, hit_out, right_first;

    assign my_end    = {1'b0, hole_reg.start} + {1'b0, hole_reg.len};
    assign left_end  = {1'b0, left_i.start} + {1'b0, left_i.len};
    assign right_end = {1'b0, right_i.start} + {1'b0, right_i.len};
    assign exact     = (hole_reg.len == {1'b0, cmd_i.req});

    always_comb begin
        case (cmd_i.op)
            OP_ALLOC:  sel = hole_reg.valid && (hole_reg.len >= {1'b0, cmd_i.req});
            OP_INSERT: sel = !hole_reg.valid || (hole_reg.start >= cmd_i.off);
            OP_MERGE:  sel = hole_reg.valid && left_i.valid
                             && (left_end == {2'b0, hole_reg.start});
            OP_DROP:   sel = hole_reg.valid && (hole_reg.start >= cmd_i.off);
            default:   sel = 1'b0;
        endcase
    end

    assign first       = sel && !chain_i.hit;
    assign hit_out     = chain_i.hit || sel;
    // right neighbor is the first joining hole: it folds into this one
    assign right_first = right_i.valid && hole_reg.valid && !hit_out
                         && (my_end == {2'b0, right_i.start});

    always_comb begin
        chain_o.hit   = hit_out;
        chain_o.rm    = chain_i.rm || (first && exact);
        chain_o.grant = chain_i.grant | (first ? hole_reg.start : '0);
    end

    always_comb begin
        hole_next = hole_reg;
        case (cmd_i.op)
            OP_ALLOC: begin
                if (chain_o.rm) begin
                    hole_next = right_i;
                end else if (first) begin
                    hole_next.start = hole_reg.start + cmd_i.req;
                    hole_next.len   = hole_reg.len - {1'b0, cmd_i.req};
                end
            end
            OP_INSERT: begin
                if (first) begin
                    hole_next.valid = 1'b1;
                    hole_next.start = cmd_i.off;
                    hole_next.len   = {1'b0, cmd_i.req};
                end else if (chain_i.hit) begin
                    hole_next = left_i;
                end
            end
            OP_MERGE: begin
                if (hit_out) begin
                    hole_next = right_i;
                end else if (right_first) begin
                    hole_next.len = LW'(right_end - {2'b0, hole_reg.start});
                end
            end
            OP_DROP: begin
                if (hit_out) begin
                    hole_next = right_i;
                end
            end
            OP_MASK: begin
                hole_next.len[LW-1] = 1'b0;
            end
            default: begin
                hole_next = hole_reg;
            end
        endcase
    end

    // only the valid bit is reset; start and length follow it
    always_ff @(posedge aclk) begin
        hole_reg.start <= hole_next.start;
        hole_reg.len   <= hole_next.len;
        if (!aresetn) begin
            hole_reg.valid <= 1'b0;
        end else begin
            hole_reg.valid <= hole_next.valid;
        end
    end

    assign hole_o = hole_reg;

endmodule
`default_nettype wire

/* rtl/first_fit_hole_allocator.sv */
// first_fit_hole_allocator: top level, request sequencer plus a row of hole cells.
// Depends on ffha_pkg and ffha_cell.
//
// Usage: words enter on s_valid/s_ready (s_data: action, range_offset,
// range_bytes) and one result word per request leaves on m_valid/m_ready
// (m_data: status, granted_offset, bytes_in_use). cfg_wr_en/cfg_wr_data
// write the arena capacity; write it only while the block is idle.
// Free holes live in a chain of MAX_HOLES+1 cells, sorted by offset; every
// cell compares against the request in parallel and a select bit ripples
// down the chain to pick the first match, and neighbors shift in the same cycle.
// Allocate or zero-length: the result word is registered from the execute
// state; no new word is accepted before that result is registered.
// Free: an insert step, a merge step for each joining neighbor
// (0..MAX_HOLES), a step that finds no further merge, then a step that
// settles or refuses the free and registers its result.
// One request is in flight at a time; the next is accepted once the
// result is registered and the output register is free or being drained.
// Stalling m_ready holds the result word and blocks new requests.
// Reset (aresetn low, synchronous) empties the hole table and clears the
// high-water mark, bytes in use and capacity; no clearing pass is needed.
`default_nettype none
module first_fit_hole_allocator #(
    parameter int MAX_HOLES = ffha_pkg::MAX_HOLES_DEF
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    cfg_wr_en,
    input  wire logic [ffha_pkg::AW-1:0] cfg_wr_data,
    input  wire logic                    s_valid,
    output logic                         s_ready,
    input  wire ffha_pkg::req_t          s_data,
    output logic                         m_valid,
    input  wire logic                    m_ready,
    output ffha_pkg::rsp_t               m_data
);
    import ffha_pkg::*;

    localparam int NCELL = MAX_HOLES + 1;   // one spare slot before merging

    seq_state_t     state_reg, state_next;
    logic [AW-1:0]  cap_reg;
    logic [AW-1:0]  hw_reg, hw_next;
    logic [AW-1:0]  used_reg, used_next;
    req_t           req_reg;
    logic           m_valid_reg, m_valid_next;
    rsp_t           m_data_reg, m_data_next;

    cell_cmd_t      cmd;
    chain_t         chain_w [0:NCELL];
    hole_t          hole_w  [0:NCELL-1];

    logic           accept;
    logic [AW-1:0]  room, clip_len;
    logic [AW:0]    bump_sum, used_grow;
    logic [AW-1:0]  used_add, used_sub;
    logic           any_hit, table_full;

    // ---------------- cell row ----------------
    assign chain_w[0] = '0;

    for (genvar i = 0; i < NCELL; i++) begin : g_cell
        hole_t left_h, right_h;
        if (i == 0) begin : g_l0
            assign left_h = '0;
        end else begin : g_l
            assign left_h = hole_w[i-1];
        end
        if (i == NCELL - 1) begin : g_rn
            assign right_h = '0;
        end else begin : g_r
            assign right_h = hole_w[i+1];
        end
        ffha_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .cmd_i   (cmd),
            .left_i  (left_h),
            .right_i (right_h),
            .chain_i (chain_w[i]),
            .chain_o (chain_w[i+1]),
            .hole_o  (hole_w[i])
        );
    end

    assign any_hit    = chain_w[NCELL].hit;
    // spare slot in use and nothing to merge: table overflow
    assign table_full = hole_w[NCELL-1].valid && !any_hit;

    // ---------------- request intake ----------------
    assign s_ready = (state_reg == S_IDLE) && (!m_valid_reg || m_ready);
    assign accept  = s_valid && s_ready;

    // frees are clipped so the range does not run past the top of the address space
    assign room     = ADDR_MASK - s_data.range_offset;
    assign clip_len = (s_data.action == ACT_FREE && s_data.range_bytes > room)
                      ? room : s_data.range_bytes;

    assign bump_sum  = {1'b0, hw_reg} + {1'b0, req_reg.range_bytes};
    assign used_grow = {1'b0, used_reg} + {1'b0, req_reg.range_bytes};
    assign used_add  = used_grow[AW] ? ADDR_MASK : used_grow[AW-1:0];
    assign used_sub  = (used_reg > req_reg.range_bytes)
                       ? used_reg - req_reg.range_bytes : '0;

    // ---------------- next state ----------------
    always_comb begin
        case (state_reg)
            S_IDLE:  state_next = accept ? S_EXEC : S_IDLE;
            S_EXEC:  state_next = (req_reg.action == ACT_FREE && req_reg.range_bytes != '0)
                                  ? S_MERGE : S_IDLE;
            S_MERGE: state_next = table_full ? S_DROP : (any_hit ? S_MERGE : S_FIN);
            S_DROP:  state_next = S_IDLE;
            S_FIN:   state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // ---------------- outputs and datapath ----------------
    always_comb begin
        cmd.off      = req_reg.range_offset;
        cmd.req      = req_reg.range_bytes;
        cmd.op       = OP_HOLD;
        hw_next      = hw_reg;
        used_next    = used_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;

        case (state_reg)
            S_EXEC: begin
                if (req_reg.range_bytes == '0) begin
                    m_valid_next = 1'b1;
                    m_data_next  = '{status: ST_ZERO, granted_offset: '0,
                                     bytes_in_use: used_reg};
                end else if (req_reg.action == ACT_ALLOC) begin
                    cmd.op       = OP_ALLOC;
                    m_valid_next = 1'b1;
                    if (any_hit) begin
                        used_next   = used_add;
                        m_data_next = '{status: ST_OK, granted_offset: chain_w[NCELL].grant,
                                        bytes_in_use: used_add};
                    end else if (bump_sum <= {1'b0, cap_reg}) begin
                        hw_next     = bump_sum[AW-1:0];
                        used_next   = used_add;
                        m_data_next = '{status: ST_OK, granted_offset: hw_reg,
                                        bytes_in_use: used_add};
                    end else begin
                        m_data_next = '{status: ST_NOSPACE, granted_offset: '0,
                                        bytes_in_use: used_reg};
                    end
                end else begin
                    cmd.op = OP_INSERT;
                end
            end
            S_MERGE: begin
                cmd.op = OP_MERGE;
            end
            S_DROP: begin
                // take the new hole back out: first valid slot at or past it
                cmd.op       = OP_DROP;
                m_valid_next = 1'b1;
                m_data_next  = '{status: ST_FULL, granted_offset: '0,
                                 bytes_in_use: used_reg};
            end
            S_FIN: begin
                cmd.op       = OP_MASK;
                used_next    = used_sub;
                m_valid_next = 1'b1;
                m_data_next  = '{status: ST_OK, granted_offset: '0,
                                 bytes_in_use: used_sub};
            end
            default: begin
                cmd.op = OP_HOLD;
            end
        endcase
    end

    // ---------------- registers ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cap_reg     <= '0;
            hw_reg      <= '0;
            used_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            hw_reg      <= hw_next;
            used_reg    <= used_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                cap_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
        if (accept) begin
            req_reg.action       <= s_data.action;
            req_reg.range_offset <= s_data.range_offset;
            req_reg.range_bytes  <= clip_len;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTHESIS
    a_fin_to_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_FIN || state_reg == S_DROP) |=> (state_reg == S_IDLE))
        else $error("sequencer did not return to idle after a free");

    a_spare_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        hole_w[NCELL-1].valid |-> (state_reg == S_MERGE || state_reg == S_DROP))
        else $error("spare hole slot occupied outside a free");

    a_grant_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_data_reg.status == ST_OK || m_data_reg.granted_offset == '0))
        else $error("nonzero grant on a failed request");
`endif

endmodule
`default_nettype wire

/* sim/first_fit_hole_allocator_test.sv */
// Self-checking bench for first_fit_hole_allocator: directed and random
// allocate/free words against a behavioral hole-table model.
// Depends on ffha_pkg and the allocator RTL.
`default_nettype none

module first_fit_hole_allocator_test;
    timeunit 1ns;
    timeprecision 1ps;
    import ffha_pkg::*;

    localparam int HOLES = 16;
    localparam longint LIMIT = 2000000;

    // Behavioral copy of the allocator plus the queue of expected words.
    class hole_table_board;
        bit [AW-1:0] hs[HOLES];
        bit [AW-1:0] hl[HOLES];
        int unsigned cnt;
        bit [AW-1:0] hw, used, cap;
        rsp_t pending[$];
        int errors, checked, n_full, n_nospace, n_merge;

        function void clear();
            cnt = 0; hw = 0; used = 0; cap = 0;
            pending.delete();
        endfunction

        function void note_request(req_t r);
            rsp_t e;
            bit [AW-1:0] len;
            bit [AW:0] sum;
            bit [AW:0] ms[HOLES+1], ml[HOLES+1];
            bit [AW-1:0] ts[HOLES+1], tl[HOLES+1];
            int pos, m, i;
            bit done;
            len = r.range_bytes;
            e = '0;
            if (r.action == ACT_FREE && len > ADDR_MASK - r.range_offset)
                len = ADDR_MASK - r.range_offset;
            if (len == 0) begin
                e.status = ST_ZERO;
            end else if (r.action == ACT_ALLOC) begin
                done = 0;
                for (i = 0; i < cnt && !done; i++) begin
                    if (hl[i] >= len) begin
                        done = 1;
                        e.granted_offset = hs[i];
                        if (hl[i] == len) begin
                            for (int j = i; j < cnt - 1; j++) begin
                                hs[j] = hs[j+1]; hl[j] = hl[j+1];
                            end
                            cnt--;
                        end else begin
                            hs[i] += len; hl[i] -= len;
                        end
                    end
                end
                if (!done) begin
                    sum = {1'b0, hw} + {1'b0, len};
                    if (sum <= {1'b0, cap}) begin
                        done = 1;
                        e.granted_offset = hw;
                        hw = sum[AW-1:0];
                    end
                end
                if (done) begin
                    e.status = ST_OK;
                    sum = {1'b0, used} + {1'b0, len};
                    used = sum[AW] ? ADDR_MASK : sum[AW-1:0];
                end else begin
                    e.status = ST_NOSPACE;
                    n_nospace++;
                end
            end else begin
                pos = 0;
                while (pos < cnt && hs[pos] < r.range_offset) pos++;
                for (i = 0; i < pos; i++) begin ts[i] = hs[i]; tl[i] = hl[i]; end
                ts[pos] = r.range_offset; tl[pos] = len;
                for (i = pos; i < cnt; i++) begin ts[i+1] = hs[i]; tl[i+1] = hl[i]; end
                ms[0] = {1'b0, ts[0]}; ml[0] = {1'b0, tl[0]}; m = 1;
                for (i = 1; i < cnt + 1; i++) begin
                    if (ms[m-1] + ml[m-1] == {1'b0, ts[i]}) begin
                        ml[m-1] += {1'b0, tl[i]};
                        n_merge++;
                    end else begin
                        ms[m] = {1'b0, ts[i]}; ml[m] = {1'b0, tl[i]}; m++;
                    end
                end
                if (m > HOLES) begin
                    e.status = ST_FULL;
                    n_full++;
                end else begin
                    for (i = 0; i < m; i++) begin
                        hs[i] = ms[i][AW-1:0]; hl[i] = ml[i][AW-1:0];
                    end
                    cnt = m;
                    used = used > len ? used - len : '0;
                    e.status = ST_OK;
                end
            end
            e.bytes_in_use = used;
            pending = {pending, e};
        endfunction

        function void check_result(rsp_t got);
            rsp_t e;
            checked++;
            if (pending.size() == 0) begin
                $error("result word with nothing expected: %p", got);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.status !== e.status) begin
                $error("status: expected %0d, actual %0d", e.status, got.status);
                errors++;
            end
            if (got.granted_offset !== e.granted_offset) begin
                $error("granted_offset: expected %0h, actual %0h",
                       e.granted_offset, got.granted_offset);
                errors++;
            end
            if (got.bytes_in_use !== e.bytes_in_use) begin
                $error("bytes_in_use: expected %0h, actual %0h",
                       e.bytes_in_use, got.bytes_in_use);
                errors++;
            end
        endfunction
    endclass

    logic aclk = 0, aresetn = 0;
    logic cfg_wr_en = 0;
    logic [AW-1:0] cfg_wr_data = '0;
    logic s_valid = 0, s_ready, m_valid, m_ready = 0;
    req_t s_data = '0;
    rsp_t m_data;

    hole_table_board board;
    int send_idle_pct = 0, recv_stall_pct = 0;
    int hold_off = 0;        // receiver forced stall, counted in cycles
    longint cycles = 0;
    int sent = 0;
    // Live allocations, so random frees usually return real ranges.
    bit [AW-1:0] live_off[$], live_len[$];

    first_fit_hole_allocator dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Run limit: way above the slowest legal run.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("first_fit_hole_allocator_test: FAIL");
            $finish;
        end
    end

    // Receiver: random stall, plus a counted hold-off when one is requested.
    always @(posedge aclk) begin
        if (m_valid && m_ready) board.check_result(m_data);
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_ready <= 0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Send one word; note it in the model on acceptance. Valid stays high
    // after acceptance only until the next call drives a new word or idles.
    task automatic send_word(logic act, logic [AW-1:0] off, logic [AW-1:0] len);
        req_t r;
        r.action = act; r.range_offset = off; r.range_bytes = len;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 0;
            @(posedge aclk);
        end
        s_valid <= 1;
        s_data <= r;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        board.note_request(r);
        sent++;
    endtask

    task automatic drain();
        s_valid <= 0;
        while (board.pending.size() != 0) @(posedge aclk);
        repeat (4 + HOLES) @(posedge aclk);
    endtask

    task automatic write_capacity(logic [AW-1:0] c);
        drain();
        cfg_wr_en <= 1;
        cfg_wr_data <= c;
        @(posedge aclk);
        cfg_wr_en <= 0;
        board.cap = c;
        @(posedge aclk);
    endtask

    // Allocate and remember the grant if the model says it succeeds.
    task automatic alloc_word(logic [AW-1:0] len);
        rsp_t e;
        send_word(ACT_ALLOC, AW'($urandom), len);
        e = board.pending[$];
        if (e.status == ST_OK && live_off.size() < 64) begin
            live_off = {live_off, e.granted_offset};
            live_len = {live_len, len};
        end
    endtask

    task automatic free_live();
        int k;
        bit [AW-1:0] o, l;
        k = $urandom_range(live_off.size() - 1);
        o = live_off[k]; l = live_len[k];
        live_off.delete(k); live_len.delete(k);
        send_word(ACT_FREE, o, l);
    endtask

    task automatic random_phase(int n, logic [AW-1:0] cap, int maxlen);
        logic [AW-1:0] o;
        write_capacity(cap);
        live_off.delete(); live_len.delete();
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(9))
                0, 1, 2, 3, 4: alloc_word(AW'($urandom_range(maxlen, 1)));
                5, 6, 7: begin
                    if (live_off.size() != 0) free_live();
                    else alloc_word(AW'($urandom_range(maxlen, 1)));
                end
                8: begin
                    // scattered free anywhere, often fills the table
                    o = AW'({$urandom, $urandom});
                    if ($urandom_range(1))
                        o = AW'({1'b0, o} % ({1'b0, cap} + 1'b1));
                    send_word(ACT_FREE, o, AW'($urandom_range(maxlen, 0)));
                end
                default: begin
                    o = AW'({$urandom, $urandom});
                    send_word(1'($urandom_range(1)), o, AW'({$urandom, $urandom}));
                end
            endcase
        end
    endtask

    initial begin
        board = new();
        board.clear();
        repeat (4) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // Directed: zero capacity, zero lengths, extremes, exact fit,
        // carve, merge on both sides, clipping past the top, table full.
        send_word(ACT_ALLOC, '0, 1);                 // no space at capacity 0
        send_word(ACT_ALLOC, '0, '0);                // zero length
        send_word(ACT_FREE, ADDR_MASK, 5);           // clipped to nothing
        write_capacity(ADDR_MASK);
        send_word(ACT_ALLOC, ADDR_MASK, 100);
        send_word(ACT_ALLOC, '0, 200);
        send_word(ACT_ALLOC, '0, 300);
        send_word(ACT_FREE, 100, 200);               // single hole
        send_word(ACT_ALLOC, '0, 50);                // carve front
        send_word(ACT_ALLOC, '0, 150);               // exact fit
        send_word(ACT_FREE, 0, 100);
        send_word(ACT_FREE, 100, 200);               // merge left
        send_word(ACT_FREE, 300, 300);               // merge left again
        send_word(ACT_FREE, ADDR_MASK - 10, ADDR_MASK); // clipped
        send_word(ACT_ALLOC, '0, ADDR_MASK);         // no space at top
        drain();
        for (int i = 0; i < 18; i++)                 // overflow the table
            send_word(ACT_FREE, 36'h100000 + i * 64, 8);
        send_word(ACT_FREE, 36'h100000 + 8, 56);     // merge both sides
        drain();

        // Random phases with different idle mixes and capacities.
        send_idle_pct = 0;  recv_stall_pct = 0;
        random_phase(120, 36'd4096, 300);
        send_idle_pct = 65; recv_stall_pct = 0;
        random_phase(120, 36'd1 << 20, 4000);
        send_idle_pct = 0;  recv_stall_pct = 65;
        random_phase(120, 36'd600, 64);
        // Long receiver hold-off while the sender keeps offering words.
        send_idle_pct = 0;  recv_stall_pct = 0;
        write_capacity(36'd2048);
        hold_off <= 300;
        random_phase(40, 36'd2048, 128);
        send_idle_pct = 38; recv_stall_pct = 38;
        random_phase(120, ADDR_MASK, 1 << 30);
        send_idle_pct = 10; recv_stall_pct = 20;
        random_phase(80, 36'd0, 16);
        drain();
        repeat (20) @(posedge aclk);

        $display("covered %0d words, %0d results; %0d no-space, %0d table-full, %0d merges",
                 sent, board.checked, board.n_nospace, board.n_full, board.n_merge);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("first_fit_hole_allocator_test: PASS");
        else
            $display("first_fit_hole_allocator_test: FAIL");
        $finish;
    end
endmodule

`default_nettype wire

/* filelist.f */
rtl/ffha_pkg.sv
rtl/ffha_cell.sv
rtl/first_fit_hole_allocator.sv
sim/first_fit_hole_allocator_test.sv
